>>> rtl/fbm_pkg.sv
// Shared types, constants and codes for the fader/button MIDI event generator.
// Depends on nothing; fbm_dp, fbm_ctrl and the top level import it.
package fbm_pkg;

  // Field widths
  localparam int FADER_W    = 12;
  localparam int DATA_W     = 7;
  localparam int PITCH_W    = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;

  // Default full-scale fader reading
  localparam int FADER_FULL_SCALE_DEF = 4095;

  // Quantization mask for the fader sample
  localparam logic [FADER_W-1:0] QUANT_MASK = 12'hFF0;

  // MIDI status nibbles
  localparam logic [7:0] ST_CC    = 8'hB0;
  localparam logic [7:0] ST_PITCH = 8'hE0;
  localparam logic [7:0] ST_NOTE_ON  = 8'h90;
  localparam logic [7:0] ST_NOTE_OFF = 8'h80;

  // Clamp limit for control change values
  localparam int CC_MAX = 127;

  // USB MIDI code index numbers
  localparam logic [3:0] CI_CC       = 4'd11;
  localparam logic [3:0] CI_PITCH    = 4'd14;
  localparam logic [3:0] CI_NOTE_ON  = 4'd9;
  localparam logic [3:0] CI_NOTE_OFF = 4'd8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FADER_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADER_CC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_RANGE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BTN_MODE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BTN_TOGGLE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BTN_CC      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BTN_NOTE    = 3'd7;

  // Configuration reset values
  localparam logic [20:0] FADER_CC_RST    = 21'd127;
  localparam logic [27:0] PITCH_RANGE_RST = 28'd16383;
  localparam logic [20:0] BTN_CC_RST      = 21'd16256;
  localparam logic [13:0] BTN_NOTE_RST    = 14'd7807;

  // Input word
  typedef struct packed {
    logic [FADER_W-1:0] fader_sample;
    logic               button_level;
    logic               force_refresh;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [3:0]        code_index;
    logic [7:0]        status_byte;
    logic [DATA_W-1:0] data_one;
    logic [DATA_W-1:0] data_two;
    logic              led_on;
    logic              last;
  } out_word_t;

  // Divider operand selection
  typedef enum logic [1:0] {
    DIV_RANGE = 2'd0,  // full scale / |range|
    DIV_FADER = 2'd1,  // fader / previous quotient
    DIV_SCALE = 2'd2   // |range| / full scale
  } div_sel_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     sc_clear;
    logic     sc_quot;
    logic     sc_mul;
    logic     fin;
    logic     emit_f;
    logic     emit_b;
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic fader_ev;
    logic button_ev;
    logic range_zero;
    logic range_ge_full;
    logic div_done;
    logic quot_zero;
    logic out_free;
  } dp_sts_t;

endpackage

>>> rtl/fbm_div.sv
// Iterative restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing beyond its parameter.
module fbm_div #(
  parameter int DIV_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W:0]   rem_r;
  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DIV_W:0] rem_sh;
  logic [DIV_W:0] rem_diff;
  logic           rem_ge;

  // Shift in the next dividend bit and try the subtract
  assign rem_sh   = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, dvs_r};
  assign rem_diff = rem_sh - {1'b0, dvs_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder / quotient shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_ge ? rem_diff : rem_sh;
      quo_r <= {quo_r[DIV_W-2:0], rem_ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/fbm_dp.sv
// Datapath: config registers, scan state, scaling arithmetic and output register.
// Depends on fbm_pkg and fbm_div.
module fbm_dp
  import fbm_pkg::*;
#(
  parameter int FADER_FULL_SCALE = FADER_FULL_SCALE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  in_word_t              in_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_stall,
  output logic                  out_valid,
  output out_word_t             out_word
);

  localparam int FS_W   = $clog2(FADER_FULL_SCALE + 1);
  localparam int DIV_W  = (FS_W > PITCH_W) ? FS_W : PITCH_W;
  localparam int PROD_W = FADER_W + DIV_W;
  localparam int SC_W   = PROD_W + 1;
  localparam int VAL_W  = SC_W + 1;
  localparam logic [DIV_W-1:0] FULL = DIV_W'(FADER_FULL_SCALE);

  // Configuration registers
  logic        fader_mode_cc_r;
  logic [3:0]  midi_channel_r;
  logic [20:0] fader_cc_setup_r;
  logic [27:0] pitch_range_r;
  logic        button_mode_cc_r;
  logic        button_toggle_r;
  logic [20:0] button_cc_setup_r;
  logic [13:0] button_note_setup_r;

  // Scan state
  logic [FADER_W-1:0] held_fader_r;
  logic               prev_level_r;
  logic               button_state_r;
  logic               fader_ev_r;
  logic               button_ev_r;

  // Scaling
  logic [PITCH_W-1:0]    lo_r;
  logic [PITCH_W-1:0]    range_mag_r;
  logic                  range_neg_r;
  logic signed [SC_W-1:0]  scaled_r;
  logic signed [VAL_W-1:0] val_r;

  // Output register
  logic      out_valid_r;
  out_word_t out_word_r;

  logic [FADER_W-1:0] sample;
  logic               flip;
  logic [PITCH_W-1:0] lo_sel;
  logic [PITCH_W-1:0] hi_sel;
  logic [PITCH_W:0]   range_s;
  logic [PITCH_W-1:0] range_abs;
  logic [DIV_W-1:0]   div_dividend;
  logic [DIV_W-1:0]   div_divisor;
  logic [DIV_W-1:0]   div_quo;
  logic               div_done;
  logic [PROD_W-1:0]  product;
  logic [SC_W-1:0]    quo_ext;
  logic signed [VAL_W-1:0] val_nxt;
  logic [DATA_W-1:0]  cc_val;
  out_word_t          fader_word;
  out_word_t          button_word;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fader_mode_cc_r     <= 1'b0;
      midi_channel_r      <= '0;
      fader_cc_setup_r    <= FADER_CC_RST;
      pitch_range_r       <= PITCH_RANGE_RST;
      button_mode_cc_r    <= 1'b0;
      button_toggle_r     <= 1'b0;
      button_cc_setup_r   <= BTN_CC_RST;
      button_note_setup_r <= BTN_NOTE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FADER_MODE:  fader_mode_cc_r     <= cfg_data[0];
        CFG_CHANNEL:     midi_channel_r      <= cfg_data[3:0];
        CFG_FADER_CC:    fader_cc_setup_r    <= cfg_data[20:0];
        CFG_PITCH_RANGE: pitch_range_r       <= cfg_data[27:0];
        CFG_BTN_MODE:    button_mode_cc_r    <= cfg_data[0];
        CFG_BTN_TOGGLE:  button_toggle_r     <= cfg_data[0];
        CFG_BTN_CC:      button_cc_setup_r   <= cfg_data[20:0];
        CFG_BTN_NOTE:    button_note_setup_r <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // Scan decode: quantize, detect button flip, pick the scaling range
  assign sample = in_word.fader_sample & QUANT_MASK;
  assign flip   = button_toggle_r ? (in_word.button_level & ~prev_level_r)
                                  : (in_word.button_level ^ prev_level_r);
  assign lo_sel = fader_mode_cc_r ? {7'd0, fader_cc_setup_r[13:7]} : pitch_range_r[27:14];
  assign hi_sel = fader_mode_cc_r ? {7'd0, fader_cc_setup_r[6:0]}  : pitch_range_r[13:0];
  assign range_s   = {1'b0, hi_sel} - {1'b0, lo_sel};
  assign range_abs = range_s[PITCH_W] ? PITCH_W'(-range_s) : range_s[PITCH_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_fader_r   <= '0;
      prev_level_r   <= 1'b0;
      button_state_r <= 1'b0;
      fader_ev_r     <= 1'b0;
      button_ev_r    <= 1'b0;
    end else if (cmd.load) begin
      held_fader_r   <= sample;
      prev_level_r   <= in_word.button_level;
      button_state_r <= button_state_r ^ flip;
      fader_ev_r     <= in_word.force_refresh | (sample != held_fader_r);
      button_ev_r    <= in_word.force_refresh | flip;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo_r        <= lo_sel;
      range_mag_r <= range_abs;
      range_neg_r <= range_s[PITCH_W];
    end
  end

  // Shared divider and its operand select
  always_comb begin
    case (cmd.div_sel)
      DIV_RANGE: begin
        div_dividend = FULL;
        div_divisor  = DIV_W'(range_mag_r);
      end
      DIV_FADER: begin
        div_dividend = DIV_W'(held_fader_r);
        div_divisor  = div_quo;
      end
      DIV_SCALE: begin
        div_dividend = DIV_W'(range_mag_r);
        div_divisor  = FULL;
      end
      default: begin
        div_dividend = FULL;
        div_divisor  = FULL;
      end
    endcase
  end

  fbm_div #(
    .DIV_W(DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Scaled part: zero, signed quotient, or fader times quotient
  assign product = PROD_W'(held_fader_r) * PROD_W'(div_quo);
  assign quo_ext = SC_W'(div_quo);

  always_ff @(posedge clk) begin
    if (cmd.sc_clear) begin
      scaled_r <= '0;
    end else if (cmd.sc_quot) begin
      scaled_r <= range_neg_r ? -$signed(quo_ext) : $signed(quo_ext);
    end else if (cmd.sc_mul) begin
      scaled_r <= $signed({1'b0, product});
    end
  end

  // Add the range start (lo) back
  assign val_nxt = $signed({scaled_r[SC_W-1], scaled_r})
                 + $signed({{(VAL_W-PITCH_W){1'b0}}, lo_r});

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      val_r <= val_nxt;
    end
  end

  // Result words
  always_comb begin
    if (val_r < 0) begin
      cc_val = '0;
    end else if (val_r > VAL_W'(CC_MAX)) begin
      cc_val = DATA_W'(CC_MAX);
    end else begin
      cc_val = val_r[DATA_W-1:0];
    end
  end

  always_comb begin
    fader_word.led_on = button_state_r;
    fader_word.last   = ~button_ev_r;
    if (fader_mode_cc_r) begin
      fader_word.code_index  = CI_CC;
      fader_word.status_byte = ST_CC | {4'd0, midi_channel_r};
      fader_word.data_one    = fader_cc_setup_r[20:14];
      fader_word.data_two    = cc_val;
    end else begin
      fader_word.code_index  = CI_PITCH;
      fader_word.status_byte = ST_PITCH | {4'd0, midi_channel_r};
      fader_word.data_one    = val_r[6:0];
      fader_word.data_two    = val_r[13:7];
    end
  end

  always_comb begin
    button_word.led_on = button_state_r;
    button_word.last   = 1'b1;
    if (button_mode_cc_r) begin
      button_word.code_index  = CI_CC;
      button_word.status_byte = ST_CC | {4'd0, midi_channel_r};
      button_word.data_one    = button_cc_setup_r[20:14];
      button_word.data_two    = button_state_r ? button_cc_setup_r[13:7]
                                               : button_cc_setup_r[6:0];
    end else begin
      button_word.code_index  = button_state_r ? CI_NOTE_ON : CI_NOTE_OFF;
      button_word.status_byte = (button_state_r ? ST_NOTE_ON : ST_NOTE_OFF)
                              | {4'd0, midi_channel_r};
      button_word.data_one    = button_note_setup_r[13:7];
      button_word.data_two    = button_note_setup_r[6:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_f || cmd.emit_b) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_f) begin
      out_word_r <= fader_word;
    end else if (cmd.emit_b) begin
      out_word_r <= button_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Status back to the controller
  assign sts.fader_ev      = fader_ev_r;
  assign sts.button_ev     = button_ev_r;
  assign sts.range_zero    = (range_mag_r == '0);
  assign sts.range_ge_full = ~range_neg_r && (DIV_W'(range_mag_r) >= FULL);
  assign sts.div_done      = div_done;
  assign sts.quot_zero     = (div_quo == '0);
  assign sts.out_free      = ~out_valid_r | ~out_stall;

endmodule

>>> rtl/fbm_ctrl.sv
// Controller: sequences one scan through load, divide, scale and emit steps.
// Depends on fbm_pkg.
module fbm_ctrl
  import fbm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_WAIT_RNG,
    S_WAIT_FDR,
    S_WAIT_SCL,
    S_FIN,
    S_EMIT_F,
    S_BTN
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = DIV_RANGE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.fader_ev) begin
          state_nxt = S_BTN;
        end else if (sts.range_zero) begin
          cmd.sc_clear = 1'b1;
          state_nxt    = S_FIN;
        end else if (sts.range_ge_full) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SCALE;
          state_nxt     = S_WAIT_SCL;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_RANGE;
          state_nxt     = S_WAIT_RNG;
        end
      end
      S_WAIT_RNG: begin
        if (sts.div_done) begin
          if (sts.quot_zero) begin
            cmd.sc_clear = 1'b1;
            state_nxt    = S_FIN;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_FADER;
            state_nxt     = S_WAIT_FDR;
          end
        end
      end
      S_WAIT_FDR: begin
        if (sts.div_done) begin
          cmd.sc_quot = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_WAIT_SCL: begin
        if (sts.div_done) begin
          cmd.sc_mul = 1'b1;
          state_nxt  = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_EMIT_F;
      end
      S_EMIT_F: begin
        if (sts.out_free) begin
          cmd.emit_f = 1'b1;
          state_nxt  = sts.button_ev ? S_BTN : S_IDLE;
        end
      end
      S_BTN: begin
        if (!sts.button_ev) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_b = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/fader_button_midi_event_gen.sv
// Top level of the fader/button MIDI event generator: controller plus datapath.
// Depends on fbm_pkg, fbm_ctrl, fbm_dp (which holds fbm_div).
//
//   Port group   Direction  Handshake          Word
//   in_*         input      in_valid/in_stall  in_word_t  (one scan)
//   out_*        output     out_valid/stall    out_word_t (zero to two events)
//   cfg_*        input      cfg_we             cfg_index / cfg_data
//
// A fader event needs no divide when its range is zero, one when the range is
// at least full scale or the first quotient is zero, and two otherwise, on the
// shared one-bit-per-cycle divider, DIV_W being its width (14 at the default
// full scale). Reset is synchronous and active low and
// restores the register defaults. in_stall is high while a scan is in work;
// a stalled output word holds, and the next scan may be taken while the last
// event still waits in the output register.
module fader_button_midi_event_gen
  import fbm_pkg::*;
#(
  parameter int FADER_FULL_SCALE = FADER_FULL_SCALE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  fbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fbm_dp #(
    .FADER_FULL_SCALE(FADER_FULL_SCALE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
